@@ design/scdma_pkg.sv @@
// ---------------------------------------------------------------------------
// scdma_pkg
// Shared types, codes and constants of the surface copy register block.
// ---------------------------------------------------------------------------
`default_nettype none

package scdma_pkg;

   // field widths
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned WADDR_W    = 8;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned SLOT_W     = 6;
   localparam int unsigned ADDR_W     = 35;
   localparam int unsigned ROW_BYTES_W = 19;
   localparam int unsigned DIM_W      = 16;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned FMT_W      = 5;

   // request codes
   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_STEP  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ROW  = 2'd2;

   // write aliases selected by the low address bits
   typedef enum logic [1:0] {
      ALIAS_WRITE  = 2'd0,
      ALIAS_SET    = 2'd1,
      ALIAS_CLEAR  = 2'd2,
      ALIAS_TOGGLE = 2'd3
   } alias_type;

   // slot map
   localparam logic [SLOT_W-1:0] SLOT_CTRL      = 6'd0;
   localparam logic [SLOT_W-1:0] SLOT_STAT      = 6'd1;
   localparam logic [SLOT_W-1:0] SLOT_OUT_CTRL  = 6'd2;
   localparam logic [SLOT_W-1:0] SLOT_OUT_BUF   = 6'd3;
   localparam logic [SLOT_W-1:0] SLOT_OUT_PITCH = 6'd5;
   localparam logic [SLOT_W-1:0] SLOT_OUT_LRC   = 6'd6;
   localparam logic [SLOT_W-1:0] SLOT_PS_BUF    = 6'd12;
   localparam logic [SLOT_W-1:0] SLOT_PS_PITCH  = 6'd15;

   // control and status bits
   localparam int unsigned CTRL_ENABLE  = 0;
   localparam int unsigned CTRL_CLKGATE = 30;
   localparam int unsigned CTRL_SFTRST  = 31;
   localparam int unsigned STAT_IRQ0    = 0;

   // formats with two bytes per pixel
   localparam logic [FMT_W-1:0] FMT_HALF_LO = 5'h08;
   localparam logic [FMT_W-1:0] FMT_HALF_HI = 5'h0f;

   // write, set, clear or toggle against the current value
   function automatic logic [DATA_W-1:0] alias_apply(input logic [DATA_W-1:0] cur,
                                                     input alias_type a,
                                                     input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] r;
      case (a)
         ALIAS_WRITE:  r = v;
         ALIAS_SET:    r = cur | v;
         ALIAS_CLEAR:  r = cur & ~v;
         ALIAS_TOGGLE: r = cur ^ v;
         default:      r = v;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/scdma_ram.sv @@
// ---------------------------------------------------------------------------
// scdma_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module scdma_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/surface_copy_dma_register_block_unit.sv @@
// Pipeline: the slot file is read in the accept cycle; stage one does the read-modify-write
//   and forms the result, which the output register takes when stage one advances.
// Throughput: one item per cycle unless the output stalls, set by the separate read and
//   write ports of the slot file, with forwarding when back-to-back items share a slot.
// Reset: control, status, interrupt, pass state and per-slot valid bits clear at once;
//   a slot never written reads as zero, so no clearing pass is needed.
// ---------------------------------------------------------------------------
// surface_copy_dma_register_block_unit
// Register block of a surface copy engine: aliased register accesses and
// row-by-row copy requests driven by step items.
// ---------------------------------------------------------------------------
`default_nettype none

module surface_copy_dma_register_block_unit #(
   parameter int unsigned SLOT_COUNT = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [47:0]  req_tdata,  // word_addr[7:0], write_data[39:8], abort_pass[40]
   input  wire logic [1:0]   req_tuser,  // command[1:0]
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [127:0] rsp_tdata,  // read_data[31:0], source_row_addr[66:32],
                                         // dest_row_addr[101:67], row_bytes[120:102],
                                         // irq_out[121]
   output logic      [1:0]   rsp_tuser,  // result_kind[1:0]
   output logic              rsp_tlast   // last_row
);

   localparam int unsigned AW = $clog2(SLOT_COUNT);
   localparam int unsigned SW = scdma_pkg::SLOT_W;
   localparam int unsigned XW = (AW > SW) ? AW : SW;
   localparam int unsigned DW = scdma_pkg::DATA_W;
   localparam int unsigned AD = scdma_pkg::ADDR_W;
   localparam int unsigned RB = scdma_pkg::ROW_BYTES_W;
   localparam int unsigned HW = scdma_pkg::DIM_W;

   // request fields
   logic [7:0]          req_word_addr;
   logic [DW-1:0]       req_write_data;
   logic                req_abort;
   logic [SW-1:0]       req_slot;
   logic [XW-1:0]       req_slot_x;
   logic [AW-1:0]       req_ram_addr;
   logic                req_in_range;
   logic                accept;

   assign req_word_addr  = req_tdata[7:0];
   assign req_write_data = req_tdata[39:8];
   assign req_abort      = req_tdata[40];
   assign req_slot       = req_word_addr[7:2];
   assign req_slot_x     = XW'(req_slot);
   assign req_ram_addr   = req_slot_x[AW-1:0];
   assign req_in_range   = (32'(req_slot) < 32'(SLOT_COUNT));

   // stage one registers
   logic                    s1_valid_ff, s1_valid_in;
   scdma_pkg::cmd_type      s1_cmd_ff;
   logic [SW-1:0]           s1_slot_ff;
   logic [AW-1:0]           s1_addr_ff;
   scdma_pkg::alias_type    s1_alias_ff;
   logic [DW-1:0]           s1_data_ff;
   logic                    s1_abort_ff;
   logic                    s1_range_ff;
   logic                    s1_vld_ff;
   logic                    fwd_ff;
   logic [DW-1:0]           fwd_data_ff;

   // architectural state
   logic [DW-1:0]           ctrl_ff, ctrl_in;
   logic [DW-1:0]           stat_ff, stat_in;
   logic                    irq_ff, irq_in;
   logic                    busy_ff, busy_in;
   logic [HW-1:0]           row_ff, row_in;
   logic [AD-1:0]           src_cur_ff, src_cur_in;
   logic [AD-1:0]           dst_cur_ff, dst_cur_in;
   logic [SLOT_COUNT-1:0]   vld_ff, vld_in;

   // copies of the slots that drive a pass
   logic [scdma_pkg::FMT_W-1:0] out_fmt_ff, out_fmt_in;
   logic [DW-1:0]           out_buf_ff, out_buf_in;
   logic [HW-1:0]           out_pitch_ff, out_pitch_in;
   logic [DW-1:0]           lrc_ff, lrc_in;
   logic [DW-1:0]           ps_buf_ff, ps_buf_in;
   logic [HW-1:0]           ps_pitch_ff, ps_pitch_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [scdma_pkg::KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [DW-1:0]           rsp_rd_ff, rsp_rd_in;
   logic [AD-1:0]           rsp_src_ff, rsp_src_in;
   logic [AD-1:0]           rsp_dst_ff, rsp_dst_in;
   logic [RB-1:0]           rsp_rb_ff, rsp_rb_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_irq_ff, rsp_irq_in;

   // slot file port signals
   logic                    ram_we;
   logic [DW-1:0]           ram_wdata;
   logic [DW-1:0]           ram_q;
   logic [DW-1:0]           slot_cur;
   logic                    advance;

   // row geometry
   logic [HW:0]             width1;
   logic [HW:0]             height1;
   logic [HW:0]             row_next;
   logic                    half_px;
   logic [RB-1:0]           row_len;
   logic [RB-1:0]           src_pitch;
   logic [RB-1:0]           dst_pitch;
   logic                    row_last;
   logic [DW-1:0]           ctrl_new;
   logic [DW-1:0]           stat_new;

   // handshake
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   // slot file
   scdma_ram #(
      .WIDTH (DW),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_addr_ff),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (req_ram_addr),
      .rd_data (ram_q)
   );

   // current slot value with forwarding and never-written slots as zero
   always_comb begin
      if (!s1_range_ff) begin
         slot_cur = '0;
      end else if (fwd_ff) begin
         slot_cur = fwd_data_ff;
      end else if (s1_vld_ff) begin
         slot_cur = ram_q;
      end else begin
         slot_cur = '0;
      end
   end

   // row geometry from the pass slots
   assign width1   = {1'b0, lrc_ff[31:16]} + (HW+1)'(1);
   assign height1  = {1'b0, lrc_ff[15:0]} + (HW+1)'(1);
   assign row_next = {1'b0, row_ff} + (HW+1)'(1);
   assign half_px  = (out_fmt_ff >= scdma_pkg::FMT_HALF_LO) &&
                     (out_fmt_ff <= scdma_pkg::FMT_HALF_HI);
   assign row_len    = half_px ? {1'b0, width1, 1'b0} : {width1, 2'b00};
   assign src_pitch  = (ps_pitch_ff == '0) ? row_len : RB'(ps_pitch_ff);
   assign dst_pitch  = (out_pitch_ff == '0) ? row_len : RB'(out_pitch_ff);
   assign row_last   = (row_next >= height1);

   assign ctrl_new = scdma_pkg::alias_apply(ctrl_ff, s1_alias_ff, s1_data_ff);
   assign stat_new = scdma_pkg::alias_apply(stat_ff, s1_alias_ff, s1_data_ff);
   assign ram_wdata = scdma_pkg::alias_apply(slot_cur, s1_alias_ff, s1_data_ff);

   // item execution and result formation
   always_comb begin
      ctrl_in      = ctrl_ff;
      stat_in      = stat_ff;
      irq_in       = irq_ff;
      busy_in      = busy_ff;
      row_in       = row_ff;
      src_cur_in   = src_cur_ff;
      dst_cur_in   = dst_cur_ff;
      vld_in       = vld_ff;
      out_fmt_in   = out_fmt_ff;
      out_buf_in   = out_buf_ff;
      out_pitch_in = out_pitch_ff;
      lrc_in       = lrc_ff;
      ps_buf_in    = ps_buf_ff;
      ps_pitch_in  = ps_pitch_ff;
      ram_we       = 1'b0;
      rsp_kind_in  = scdma_pkg::KIND_ACK;
      rsp_rd_in    = '0;
      rsp_src_in   = '0;
      rsp_dst_in   = '0;
      rsp_rb_in    = '0;
      rsp_last_in  = 1'b0;

      if (advance) begin
         unique case (s1_cmd_ff)
            scdma_pkg::CMD_READ: begin
               rsp_kind_in = scdma_pkg::KIND_READ;
               if (s1_slot_ff == scdma_pkg::SLOT_CTRL) begin
                  rsp_rd_in = ctrl_ff;
                  if (ctrl_ff[scdma_pkg::CTRL_SFTRST]) begin
                     rsp_rd_in[scdma_pkg::CTRL_CLKGATE] = 1'b1;
                  end
               end else if (s1_slot_ff == scdma_pkg::SLOT_STAT) begin
                  rsp_rd_in = stat_ff;
               end else begin
                  rsp_rd_in = slot_cur;
               end
            end
            scdma_pkg::CMD_WRITE: begin
               if (!busy_ff) begin
                  if (s1_slot_ff == scdma_pkg::SLOT_CTRL) begin
                     ctrl_in = ctrl_new;
                     if (ctrl_new[scdma_pkg::CTRL_ENABLE]) begin
                        row_in = '0;
                        if (out_buf_ff == '0 || ps_buf_ff == '0) begin
                           // empty buffer address, complete at once
                           ctrl_in[scdma_pkg::CTRL_ENABLE] = 1'b0;
                           stat_in[scdma_pkg::STAT_IRQ0]   = 1'b1;
                           irq_in                          = 1'b1;
                        end else begin
                           busy_in    = 1'b1;
                           src_cur_in = AD'(ps_buf_ff);
                           dst_cur_in = AD'(out_buf_ff);
                        end
                     end
                  end else if (s1_slot_ff == scdma_pkg::SLOT_STAT) begin
                     stat_in = stat_new;
                     if (!stat_new[scdma_pkg::STAT_IRQ0]) begin
                        irq_in = 1'b0;
                     end
                  end else if (s1_range_ff) begin
                     ram_we             = 1'b1;
                     vld_in[s1_addr_ff] = 1'b1;
                     if (s1_slot_ff == scdma_pkg::SLOT_OUT_CTRL) begin
                        out_fmt_in = ram_wdata[scdma_pkg::FMT_W-1:0];
                     end
                     if (s1_slot_ff == scdma_pkg::SLOT_OUT_BUF) begin
                        out_buf_in = ram_wdata;
                     end
                     if (s1_slot_ff == scdma_pkg::SLOT_OUT_PITCH) begin
                        out_pitch_in = ram_wdata[HW-1:0];
                     end
                     if (s1_slot_ff == scdma_pkg::SLOT_OUT_LRC) begin
                        lrc_in = ram_wdata;
                     end
                     if (s1_slot_ff == scdma_pkg::SLOT_PS_BUF) begin
                        ps_buf_in = ram_wdata;
                     end
                     if (s1_slot_ff == scdma_pkg::SLOT_PS_PITCH) begin
                        ps_pitch_in = ram_wdata[HW-1:0];
                     end
                  end
               end
            end
            scdma_pkg::CMD_STEP: begin
               if (busy_ff) begin
                  if (s1_abort_ff) begin
                     // failed source read ends the pass without a row
                     busy_in                         = 1'b0;
                     row_in                          = '0;
                     ctrl_in[scdma_pkg::CTRL_ENABLE] = 1'b0;
                     stat_in[scdma_pkg::STAT_IRQ0]   = 1'b1;
                     irq_in                          = 1'b1;
                  end else begin
                     rsp_kind_in = scdma_pkg::KIND_ROW;
                     rsp_src_in  = src_cur_ff;
                     rsp_dst_in  = dst_cur_ff;
                     rsp_rb_in   = row_len;
                     rsp_last_in = row_last;
                     src_cur_in  = src_cur_ff + AD'(src_pitch);
                     dst_cur_in  = dst_cur_ff + AD'(dst_pitch);
                     row_in      = row_next[HW-1:0];
                     if (row_last) begin
                        busy_in                         = 1'b0;
                        row_in                          = '0;
                        ctrl_in[scdma_pkg::CTRL_ENABLE] = 1'b0;
                        stat_in[scdma_pkg::STAT_IRQ0]   = 1'b1;
                        irq_in                          = 1'b1;
                     end
                  end
               end
            end
            default: begin
               rsp_kind_in = scdma_pkg::KIND_ACK;
            end
         endcase
      end
   end

   assign rsp_irq_in = irq_in;

   // stage one valid and output valid
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctrl_ff      <= '0;
         stat_ff      <= '0;
         irq_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         row_ff       <= '0;
         src_cur_ff   <= '0;
         dst_cur_ff   <= '0;
         vld_ff       <= '0;
         out_fmt_ff   <= '0;
         out_buf_ff   <= '0;
         out_pitch_ff <= '0;
         lrc_ff       <= '0;
         ps_buf_ff    <= '0;
         ps_pitch_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ctrl_ff      <= ctrl_in;
         stat_ff      <= stat_in;
         irq_ff       <= irq_in;
         busy_ff      <= busy_in;
         row_ff       <= row_in;
         src_cur_ff   <= src_cur_in;
         dst_cur_ff   <= dst_cur_in;
         vld_ff       <= vld_in;
         out_fmt_ff   <= out_fmt_in;
         out_buf_ff   <= out_buf_in;
         out_pitch_ff <= out_pitch_in;
         lrc_ff       <= lrc_in;
         ps_buf_ff    <= ps_buf_in;
         ps_pitch_ff  <= ps_pitch_in;
      end
   end

   // stage one payload, with forwarding of a same-slot write-back
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff   <= scdma_pkg::cmd_type'(req_tuser);
         s1_slot_ff  <= req_slot;
         s1_addr_ff  <= req_ram_addr;
         s1_alias_ff <= scdma_pkg::alias_type'(req_word_addr[1:0]);
         s1_data_ff  <= req_write_data;
         s1_abort_ff <= req_abort;
         s1_range_ff <= req_in_range;
         s1_vld_ff   <= vld_ff[req_ram_addr];
         fwd_ff      <= ram_we && (s1_slot_ff == req_slot);
         fwd_data_ff <= ram_wdata;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_rd_ff   <= rsp_rd_in;
         rsp_src_ff  <= rsp_src_in;
         rsp_dst_ff  <= rsp_dst_in;
         rsp_rb_ff   <= rsp_rb_in;
         rsp_last_ff <= rsp_last_in;
         rsp_irq_ff  <= rsp_irq_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'd0, rsp_irq_ff, rsp_rb_ff, rsp_dst_ff, rsp_src_ff, rsp_rd_ff};

   // a running pass always has enable set in the control word
   a_busy_enable: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ctrl_ff[scdma_pkg::CTRL_ENABLE])
      else $error("pass running with enable clear");

   // the interrupt line is only high while status IRQ0 is set
   a_irq_status: assert property (@(posedge clock) disable iff (reset)
      irq_ff |-> stat_ff[scdma_pkg::STAT_IRQ0])
      else $error("interrupt line high with IRQ0 clear");

   // an empty output register never blocks the request side
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("request stalled with empty output register");

   // a stalled item keeps its command and slot in stage one
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_slot_ff) &&
                                     $stable(s1_cmd_ff)))
      else $error("stage one item lost during stall");

   // row requests never carry a zero length
   a_row_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == scdma_pkg::KIND_ROW) |-> (rsp_rb_ff != '0))
      else $error("row request with zero length");

endmodule

`default_nettype wire
